### sv/kfq_pkg.sv
// ----------------------------------------------------------------------------
// kfq_pkg
// Shared types, codes and defaults for the keyed FIFO queue.
// ----------------------------------------------------------------------------
package kfq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_KEY_BITS    = 64;

   typedef logic [2:0]  opcode_type;
   typedef logic [15:0] handle_type;
   typedef logic [63:0] key_type;
   typedef logic [1:0]  port_type;
   typedef logic [1:0]  status_type;
   typedef logic [3:0]  position_type;
   typedef logic [4:0]  count_type;

   localparam opcode_type OP_ENQUEUE   = 3'd0;
   localparam opcode_type OP_DEQUEUE   = 3'd1;
   localparam opcode_type OP_REMOVE    = 3'd2;
   localparam opcode_type OP_FIND_KEY  = 3'd3;
   localparam opcode_type OP_FIND_PORT = 3'd4;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_EMPTY     = 2'd3;

   typedef struct packed {
      opcode_type opcode;
      handle_type item_handle;
      key_type    item_key;
      port_type   port_kind;
   } req_type;

   typedef struct packed {
      status_type   status;
      handle_type   found_handle;
      position_type found_position;
      count_type    entry_count;
   } rsp_type;

endpackage

### sv/keyed_fifo_queue_top.sv
// ----------------------------------------------------------------------------
// keyed_fifo_queue_top
// Ordered queue of keyed entries with search, lookup and removal by key.
// ----------------------------------------------------------------------------
// Usage: a request transaction on req_* carries one operation (enqueue,
// dequeue front, remove by key, find by key, find by port). Every request
// produces exactly one response transaction on rsp_* with a status, the
// handle and position of a match on lookups, and the entry count after the
// operation. Requests are handled one at a time: req_stall is high while an
// operation is in progress.
// Steps from the accepting edge to the response being presented:
//   enqueue, dequeue and unused opcodes: the finish state only.
//   searches: a read and a compare state per entry examined from the front.
//   removal: the search, plus a read and a write state per entry moved to close the gap
//   (none when the match is the front or the rear entry).
// The next request is taken on the edge after the response is presented.
// The steps come from the single entry memory, which has one read port
// with a registered read and is walked one entry at a time.
// The response sits in an output register; while rsp_stall is high it holds
// and the next request may still be accepted and worked on, its result
// waiting until the output register frees. Synchronous reset empties the
// queue and drops any pending response; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_fifo_queue_top #(
   parameter int QUEUE_DEPTH = kfq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int KEY_BITS    = kfq_pkg::DEFAULT_KEY_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kfq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kfq_pkg::rsp_type rsp_data
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int HDL_W   = $bits(kfq_pkg::handle_type);
   localparam int PRT_W   = $bits(kfq_pkg::port_type);
   localparam int ENTRY_W = KEY_BITS + HDL_W + PRT_W;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [PTR_W:0]     ext_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [KEY_BITS-1:0] skey_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SRD    = 3'd1;
   localparam logic [2:0] S_SCMP   = 3'd2;
   localparam logic [2:0] S_CRD    = 3'd3;
   localparam logic [2:0] S_CWR    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   // Physical address of a logical position, wrapping at the queue depth.
   function automatic ptr_type wrap_add(ptr_type base, ptr_type off);
      ext_type sum;
      sum = ext_type'(base) + ext_type'(off);
      if (sum >= ext_type'(QUEUE_DEPTH)) begin
         sum = sum - ext_type'(QUEUE_DEPTH);
      end
      return ptr_type'(sum);
   endfunction

   entry_type entry_mem [QUEUE_DEPTH];

   logic [2:0]               state_ff, state_in;
   ptr_type                  head_ff, head_in;
   cnt_type                  count_ff, count_in;
   ptr_type                  pos_ff, pos_in;
   kfq_pkg::opcode_type      op_ff, op_in;
   skey_type                 key_ff, key_in;
   kfq_pkg::port_type        port_ff, port_in;
   kfq_pkg::status_type      res_status_ff, res_status_in;
   kfq_pkg::handle_type      res_handle_ff, res_handle_in;
   kfq_pkg::position_type    res_pos_ff, res_pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   kfq_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   entry_type                rd_data_ff;

   logic                     wr_en;
   ptr_type                  wr_addr;
   entry_type                wr_data;
   ptr_type                  rd_addr;

   ext_type                  pos_next_ext;
   ext_type                  pos_next2_ext;
   logic                     at_last;
   logic                     hit;
   skey_type                 rd_key;
   kfq_pkg::handle_type      rd_handle;
   kfq_pkg::port_type        rd_port;
   logic                     is_full;
   logic                     is_empty;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rd_key    = rd_data_ff[ENTRY_W-1 -: KEY_BITS];
   assign rd_handle = rd_data_ff[PRT_W +: HDL_W];
   assign rd_port   = rd_data_ff[PRT_W-1:0];

   assign pos_next_ext  = ext_type'(pos_ff) + ext_type'(1);
   assign pos_next2_ext = ext_type'(pos_ff) + ext_type'(2);
   assign at_last       = (pos_next_ext == ext_type'(count_ff));
   assign is_full       = (count_ff == cnt_type'(QUEUE_DEPTH));
   assign is_empty      = (count_ff == '0);

   assign hit = (op_ff == kfq_pkg::OP_FIND_PORT) ? (rd_port == port_ff)
                                                 : (rd_key == key_ff);

   // During compaction the entry behind the current position is fetched.
   assign rd_addr = (state_ff == S_CRD) ? wrap_add(head_ff, ptr_type'(pos_next_ext))
                                        : wrap_add(head_ff, pos_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      port_in       = port_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = wrap_add(head_ff, ptr_type'(count_ff));
      wr_data       = {req_data.item_key[KEY_BITS-1:0], req_data.item_handle,
                       req_data.port_kind};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_data.opcode;
               key_in        = req_data.item_key[KEY_BITS-1:0];
               port_in       = req_data.port_kind;
               res_handle_in = '0;
               res_pos_in    = '0;
               res_status_in = kfq_pkg::ST_OK;
               pos_in        = '0;
               state_in      = S_FINISH;
               case (req_data.opcode)
                  kfq_pkg::OP_ENQUEUE: begin
                     if (is_full) begin
                        res_status_in = kfq_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + cnt_type'(1);
                     end
                  end
                  kfq_pkg::OP_DEQUEUE: begin
                     if (is_empty) begin
                        res_status_in = kfq_pkg::ST_EMPTY;
                     end else begin
                        head_in  = wrap_add(head_ff, ptr_type'(1));
                        count_in = count_ff - cnt_type'(1);
                     end
                  end
                  kfq_pkg::OP_REMOVE,
                  kfq_pkg::OP_FIND_KEY,
                  kfq_pkg::OP_FIND_PORT: begin
                     if (is_empty) begin
                        res_status_in = kfq_pkg::ST_NOT_FOUND;
                     end else begin
                        state_in = S_SRD;
                     end
                  end
                  default: begin
                     res_status_in = kfq_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_SRD: begin
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (hit) begin
               res_status_in = kfq_pkg::ST_OK;
               if (op_ff == kfq_pkg::OP_REMOVE) begin
                  if (at_last) begin
                     count_in = count_ff - cnt_type'(1);
                     state_in = S_FINISH;
                  end else if (pos_ff == '0) begin
                     // Removing the front entry only moves the head.
                     head_in  = wrap_add(head_ff, ptr_type'(1));
                     count_in = count_ff - cnt_type'(1);
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_CRD;
                  end
               end else begin
                  res_handle_in = rd_handle;
                  res_pos_in    = kfq_pkg::position_type'(pos_ff);
                  state_in      = S_FINISH;
               end
            end else if (at_last) begin
               res_status_in = kfq_pkg::ST_NOT_FOUND;
               state_in      = S_FINISH;
            end else begin
               pos_in   = ptr_type'(pos_next_ext);
               state_in = S_SRD;
            end
         end
         S_CRD: begin
            state_in = S_CWR;
         end
         S_CWR: begin
            wr_en   = 1'b1;
            wr_addr = wrap_add(head_ff, pos_ff);
            wr_data = rd_data_ff;
            pos_in  = ptr_type'(pos_next_ext);
            if (pos_next2_ext == ext_type'(count_ff)) begin
               count_in = count_ff - cnt_type'(1);
               state_in = S_FINISH;
            end else begin
               state_in = S_CRD;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = res_status_ff;
               rsp_data_in.found_handle   = res_handle_ff;
               rsp_data_in.found_position = res_pos_ff;
               rsp_data_in.entry_count    = kfq_pkg::count_type'(count_ff);
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      port_ff       <= port_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_pos_ff    <= res_pos_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem[rd_addr];
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_IDLE || state_ff == S_CWR))
      else $error("entry memory written outside enqueue or compaction");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCMP || state_ff == S_CWR) |-> (ext_type'(pos_ff) < ext_type'(count_ff)))
      else $error("scan position beyond occupied entries");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == kfq_pkg::ST_FULL)
         |-> (rsp_data_ff.entry_count == kfq_pkg::count_type'(QUEUE_DEPTH)))
      else $error("full status reported with room left");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == kfq_pkg::ST_EMPTY)
         |-> (rsp_data_ff.entry_count == '0))
      else $error("empty status reported with entries present");
`endif

endmodule
